### rtl/tfc_pkg.sv
// shared types, constants and crc function for the telemetry frame checker
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_START_MARKER = 2'd0;
	localparam logic [1:0] CFG_END_MARKER   = 2'd1;
	localparam logic [1:0] CFG_DEVICE_CLASS = 2'd2;

	localparam logic [7:0] START_MARKER_RST = 8'h55;
	localparam logic [7:0] END_MARKER_RST   = 8'hAA;
	localparam logic [7:0] DEVICE_CLASS_RST = 8'hE3;

	// status codes
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_MARKER   = 4'd1;
	localparam logic [3:0] ST_LENGTH   = 4'd2;
	localparam logic [3:0] ST_DEVICE   = 4'd3;
	localparam logic [3:0] ST_SHORT    = 4'd4;
	localparam logic [3:0] ST_INNER    = 4'd5;
	localparam logic [3:0] ST_CRC      = 4'd6;
	localparam logic [3:0] ST_CHECKSUM = 4'd7;
	localparam logic [3:0] ST_KIND     = 4'd8;

	// data and command kinds
	localparam logic [7:0] DK_UPLOAD    = 8'd1;
	localparam logic [7:0] DK_HOST      = 8'd2;
	localparam logic [7:0] CK_REPORT    = 8'd1;
	localparam logic [7:0] CK_SET       = 8'd3;
	localparam logic [7:0] CK_CONTROL   = 8'd5;
	localparam logic [7:0] CK_HEARTBEAT = 8'd255;

	// frame positions
	localparam logic [7:0] POS_START     = 8'd0;
	localparam logic [7:0] POS_LENGTH    = 8'd1;
	localparam logic [7:0] POS_DEV0      = 8'd2;
	localparam logic [7:0] POS_DEV1      = 8'd3;
	localparam logic [7:0] POS_DEV2      = 8'd4;
	localparam logic [7:0] POS_COMMAND   = 8'd5;
	localparam logic [7:0] POS_PAYLOAD   = 8'd6;
	localparam logic [7:0] POS_DKIND     = 8'd22;
	localparam logic [7:0] POS_INNER_HI  = 8'd23;
	localparam logic [7:0] POS_INNER_LO  = 8'd24;
	localparam logic [7:0] POS_CKIND     = 8'd25;
	localparam logic [7:0] POS_YEAR_HI   = 8'd26;
	localparam logic [7:0] POS_YEAR_LO   = 8'd27;
	localparam logic [7:0] POS_MONTH     = 8'd28;
	localparam logic [7:0] POS_DAY       = 8'd29;
	localparam logic [7:0] POS_HOUR      = 8'd30;
	localparam logic [7:0] POS_MINUTE    = 8'd31;
	localparam logic [7:0] POS_SECOND    = 8'd32;
	localparam logic [7:0] POS_MSEC_HI   = 8'd33;
	localparam logic [7:0] POS_MSEC_LO   = 8'd34;
	localparam logic [7:0] POS_SAT       = 8'd255;

	// frames of this length or less have too short a payload
	localparam logic [7:0] LEN_SHORT_MAX = 8'd29;
	localparam logic [15:0] HEADER_TRAILER_LEN = 16'd8;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0]  first_byte;
		logic [7:0]  declared_length;
		logic [15:0] crc;
		logic [7:0]  running_sum;
		logic [15:0] received_crc;
		logic [7:0]  received_checksum;
		logic [15:0] inner_length;
		logic [23:0] dev_type;
		logic [7:0]  command;
		logic [7:0]  data_kind;
		logic [7:0]  command_kind;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [15:0] millisecond;
	} frame_t;

	localparam frame_t FRAME_CLEAR = '{
		first_byte:        8'd0,
		declared_length:   8'd0,
		crc:               CRC_INIT,
		running_sum:       8'd0,
		received_crc:      16'd0,
		received_checksum: 8'd0,
		inner_length:      16'd0,
		dev_type:          24'd0,
		command:           8'd0,
		data_kind:         8'd0,
		command_kind:      8'd0,
		year:              16'd0,
		month:             8'd0,
		day:               8'd0,
		hour:              8'd0,
		minute:            8'd0,
		second:            8'd0,
		millisecond:       16'd0
	};

	// crc-16 modbus, one byte, lsb first
	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/tfc_frame_track.sv
// per-byte frame state: position, crc, sum and captured fields
`timescale 1ns / 1ps
`default_nettype none

module tfc_frame_track
	import tfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_go,
	input  wire logic [7:0] byte_in,
	input  wire logic       byte_last,
	output frame_t          frame_view,
	output logic [7:0]      frame_len
);

	frame_t     frame_q;
	frame_t     nxt;
	logic [7:0] pos_q;
	logic [7:0] pos_inc;
	logic [8:0] p9;
	logic [8:0] d9;

	assign pos_inc = (pos_q == POS_SAT) ? POS_SAT : pos_q + 8'd1;
	assign p9 = {1'b0, pos_q};
	assign d9 = {1'b0, (pos_q == POS_LENGTH) ? byte_in : frame_q.declared_length};

	always_comb begin
		nxt = frame_q;
		if (pos_q == POS_START) begin
			nxt.first_byte = byte_in;
		end else if (pos_q != POS_SAT) begin
			if (pos_q == POS_LENGTH) begin
				nxt.declared_length = byte_in;
			end
			if (p9 + 9'd3 <= d9) begin
				nxt.running_sum = frame_q.running_sum + byte_in;
			end
			if (pos_q >= POS_PAYLOAD && p9 + 9'd5 <= d9) begin
				nxt.crc = crc_feed(frame_q.crc, byte_in);
			end
			if (p9 + 9'd4 == d9) begin
				nxt.received_crc[15:8] = byte_in;
			end
			if (p9 + 9'd3 == d9) begin
				nxt.received_crc[7:0] = byte_in;
			end
			if (p9 + 9'd2 == d9) begin
				nxt.received_checksum = byte_in;
			end
			unique case (pos_q)
				POS_DEV0:     nxt.dev_type[23:16]    = byte_in;
				POS_DEV1:     nxt.dev_type[15:8]     = byte_in;
				POS_DEV2:     nxt.dev_type[7:0]      = byte_in;
				POS_COMMAND:  nxt.command            = byte_in;
				POS_DKIND:    nxt.data_kind          = byte_in;
				POS_INNER_HI: nxt.inner_length[15:8] = byte_in;
				POS_INNER_LO: nxt.inner_length[7:0]  = byte_in;
				POS_CKIND:    nxt.command_kind       = byte_in;
				POS_YEAR_HI:  nxt.year[15:8]         = byte_in;
				POS_YEAR_LO:  nxt.year[7:0]          = byte_in;
				POS_MONTH:    nxt.month              = byte_in;
				POS_DAY:      nxt.day                = byte_in;
				POS_HOUR:     nxt.hour               = byte_in;
				POS_MINUTE:   nxt.minute             = byte_in;
				POS_SECOND:   nxt.second             = byte_in;
				POS_MSEC_HI:  nxt.millisecond[15:8]  = byte_in;
				POS_MSEC_LO:  nxt.millisecond[7:0]   = byte_in;
				default: ;
			endcase
		end
	end

	// view includes the current byte; length saturates like the position
	assign frame_view = nxt;
	assign frame_len  = pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_CLEAR;
			pos_q   <= POS_START;
		end else if (byte_go) begin
			if (byte_last) begin
				frame_q <= FRAME_CLEAR;
				pos_q   <= POS_START;
			end else begin
				frame_q <= nxt;
				pos_q   <= pos_inc;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/telemetry_frame_checker_top.sv
// telemetry frame checker top level: handshakes, config registers, checks, result register
// a final byte is held in the input register, then its result is written to the result register
// throughput: one byte per cycle unless a final byte waits for room in the output register
// a finished result waits in the output register while further bytes are taken
// reset clears frame state, handshake state and restores the marker and class registers
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_checker_top
	import tfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [23:0]      dev_type,
	output logic [7:0]       command,
	output logic [7:0]       data_kind,
	output logic [7:0]       command_kind,
	output logic [15:0]      year,
	output logic [7:0]       month,
	output logic [7:0]       day,
	output logic [7:0]       hour,
	output logic [7:0]       minute,
	output logic [7:0]       second,
	output logic [15:0]      millisecond,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic [7:0] device_class_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       go_s1;

	frame_t     fv;
	logic [7:0] flen;
	logic       kind_valid;
	logic [3:0] status_d;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
			device_class_q <= DEVICE_CLASS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				CFG_DEVICE_CLASS: device_class_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register; only a final byte needs room in the output register
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= frame_end;
		end
	end

	tfc_frame_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_go    (go_s1),
		.byte_in    (byte_s1),
		.byte_last  (last_s1),
		.frame_view (fv),
		.frame_len  (flen)
	);

	always_comb begin
		case (fv.data_kind)
			DK_UPLOAD: kind_valid = (fv.command_kind == CK_REPORT)
				|| (fv.command_kind == CK_HEARTBEAT);
			DK_HOST:   kind_valid = (fv.command_kind == CK_REPORT)
				|| (fv.command_kind == CK_SET) || (fv.command_kind == CK_CONTROL);
			default:   kind_valid = 1'b0;
		endcase
	end

	// first failing check wins
	always_comb begin
		if (fv.first_byte != start_marker_q || byte_s1 != end_marker_q) begin
			status_d = ST_MARKER;
		end else if (fv.declared_length != flen) begin
			status_d = ST_LENGTH;
		end else if (fv.dev_type[23:16] != device_class_q) begin
			status_d = ST_DEVICE;
		end else if (flen <= LEN_SHORT_MAX) begin
			status_d = ST_SHORT;
		end else if (fv.inner_length != {8'd0, flen} - HEADER_TRAILER_LEN) begin
			status_d = ST_INNER;
		end else if (fv.received_crc != {fv.crc[7:0], fv.crc[15:8]}) begin
			status_d = ST_CRC;
		end else if (fv.received_checksum != fv.running_sum) begin
			status_d = ST_CHECKSUM;
		end else if (!kind_valid) begin
			status_d = ST_KIND;
		end else begin
			status_d = ST_OK;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			status       <= status_d;
			dev_type     <= fv.dev_type;
			command      <= fv.command;
			data_kind    <= fv.data_kind;
			command_kind <= fv.command_kind;
			year         <= fv.year;
			month        <= fv.month;
			day          <= fv.day;
			hour         <= fv.hour;
			minute       <= fv.minute;
			second       <= fv.second;
			millisecond  <= fv.millisecond;
		end
	end

endmodule

`default_nettype wire
